[src/sorted_priority_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared macros for the concurrent checks on the queue ports.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, entry types, operation and status codes shared by the queue files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic signed [15:0]  prio_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    tag_t  tag;
    prio_t prio;
  } entry_t;

  typedef struct packed {
    logic shift_in;
    logic by_prio;
    logic shift_out;
  } ctrl_t;

  function automatic tag_t to_tag(input logic [31:0] payload);
    logic [63:0] wide;
    wide = 64'(payload);
    return wide[TAG_BITS-1:0];
  endfunction

  function automatic logic [31:0] to_payload(input tag_t tag);
    logic [63:0] wide;
    wide = 64'(tag);
    return wide[31:0];
  endfunction

  function automatic logic [4:0] to_fill(input cnt_t cnt);
    logic [15:0] wide;
    wide = 16'(cnt);
    return wide[4:0];
  endfunction

endpackage

[src/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one list entry and moves it toward the head or the tail as ordered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
  input  logic            clk,
  input  spq_pkg::ctrl_t  ctrl,
  input  logic            occupied,
  input  spq_pkg::entry_t new_entry,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  input  logic            after_left,
  output logic            after_self,
  output spq_pkg::entry_t entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   here;

  // A cell lies at or after the insert point when it is free, when a priority
  // insert finds a strictly greater priority here, or when an earlier cell did.
  assign here       = !occupied || (ctrl.by_prio && (entry_r.prio > new_entry.prio));
  assign after_self = after_left || here;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift_out) begin
      entry_nxt = right_entry;
    end else if (ctrl.shift_in && after_self) begin
      entry_nxt = after_left ? left_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[src/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue
// Ordered list of tagged entries kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: drive in_kind, in_payload and in_priority_req and raise start. The
// transfer is taken at a rising edge with start high and busy low; busy stays
// low, so a new operation may be issued in every cycle.
// A priority insert places the entry before the first stored entry with a
// strictly greater priority, an append places it at the tail, and a remove
// takes the head entry off and returns its tag on out_head_payload.
// Each operation gives one result in the cycle after its transfer: out_valid is
// high for exactly that cycle with out_status and out_fill_count beside it.
// Throughput is one operation per cycle; every cell compares against the new
// priority in parallel and the whole row shifts in that same cycle.
// Removing from an empty list reports an empty status; an insert or append
// into a full list is dropped and reports a full status.
// Reset empties the list and clears the result strobe. The receiver cannot
// stall the result; it must take it in the cycle that out_valid marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_payload,
  input  logic [15:0] in_priority_req,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_head_payload,
  output logic [4:0]  out_fill_count
);
  import spq_pkg::*;

  cnt_t        count_r;
  cnt_t        count_nxt;
  logic        out_valid_r;
  status_t     status_r;
  status_t     status_nxt;
  logic [31:0] head_r;
  logic [31:0] head_nxt;

  logic        take;
  logic        full;
  logic        empty;
  ctrl_t       ctrl;
  entry_t      new_entry;
  entry_t      cells [DEPTH];
  logic        after [DEPTH];

  assign busy      = 1'b0;
  assign take      = start && !busy;
  assign full      = (count_r == cnt_t'(DEPTH));
  assign empty     = (count_r == '0);
  assign new_entry = '{tag: to_tag(in_payload), prio: prio_t'(in_priority_req)};

  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    head_nxt   = '0;
    if (take) begin
      case (in_kind)
        KIND_INSERT, KIND_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.shift_in = 1'b1;
            ctrl.by_prio  = (in_kind == KIND_INSERT);
            count_nxt     = count_r + cnt_t'(1);
          end
        end
        KIND_REMOVE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.shift_out = 1'b1;
            head_nxt       = to_payload(cells[0].tag);
            count_nxt      = count_r - cnt_t'(1);
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cnt_t'(i) < count_r),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cells[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == DEPTH - 1) ? cells[i] : cells[(i == DEPTH - 1) ? i : i + 1]),
      .after_left  ((i == 0) ? 1'b0 : after[(i == 0) ? 0 : i - 1]),
      .after_self  (after[i]),
      .entry       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    head_r   <= head_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_head_payload = head_r;
  assign out_fill_count   = to_fill(count_r);

endmodule

[src/spq_checker.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on result timing and status consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_top_defines.svh"

module spq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_head_payload,
  input logic [4:0]  out_fill_count
);
  import spq_pkg::*;

  logic [4:0] full_fill;
  logic       take;
  logic       no_head;
  logic       res_empty;
  logic       res_full;
  logic       res_fail;
  logic       fill_kept;
  logic       valid_prev_r;
  logic [4:0] fill_prev_r;

  assign full_fill = to_fill(cnt_t'(DEPTH));
  assign take      = start && !busy;
  assign no_head   = (out_head_payload == 32'd0);
  assign res_empty = out_valid && (out_status == ST_EMPTY);
  assign res_full  = out_valid && (out_status == ST_FULL);
  assign res_fail  = out_valid && (out_status != ST_DONE);
  assign fill_kept = (out_fill_count == fill_prev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_prev_r <= 1'b0;
    end else begin
      valid_prev_r <= out_valid;
    end
    fill_prev_r <= out_fill_count;
  end

  `SPQ_ASSERT_NEXT(a_one_result, clk, rst_n, 1'b1, out_valid == $past(take))
  `SPQ_ASSERT_SAME(a_empty_result, clk, rst_n, res_empty, out_fill_count == 5'd0 && no_head)
  `SPQ_ASSERT_SAME(a_full_result, clk, rst_n, res_full, out_fill_count == full_fill && no_head)
  `SPQ_ASSERT_SAME(a_fail_keeps_fill, clk, rst_n, res_fail && valid_prev_r, fill_kept)

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
